[rtl/owrs_pkg.sv]
// owrs_pkg: shared types, codes and helper functions for the one-wire ROM search engine.
// No dependencies; used by owrs_core, owrs_result_queue and one_wire_rom_search.
package owrs_pkg;

	// Input mode codes
	localparam logic [1:0] MODE_BEGIN    = 2'd0;
	localparam logic [1:0] MODE_PRESENCE = 2'd1;
	localparam logic [1:0] MODE_BITS     = 2'd2;

	// Result kind codes
	localparam logic [1:0] KIND_RESET    = 2'd0;
	localparam logic [1:0] KIND_BYTE     = 2'd1;
	localparam logic [1:0] KIND_BIT      = 2'd2;
	localparam logic [1:0] KIND_FINISHED = 2'd3;

	// Search phase codes
	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_PRESENCE = 2'd1;
	localparam logic [1:0] PH_SEARCH   = 2'd2;

	// Bus constants
	localparam logic [7:0] SEARCH_CMD   = 8'hF0;
	localparam logic [6:0] FAMILY_LIMIT = 7'd9;
	localparam logic [7:0] CRC_POLY     = 8'h8C;
	localparam logic [5:0] LAST_IDX     = 6'd63;

	// Result queue depth (power of two, at least 2)
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  write_value;
		logic        found;
		logic        last_device;
		logic [63:0] rom_code;
		logic [6:0]  family_discrepancy;
		logic        last_of_run;
	} result_t;

	// Dallas CRC-8, one byte, LSB first
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Command result: bus reset, byte write or bit write
	function automatic result_t make_cmd(input logic [1:0] kind, input logic [7:0] value,
			input logic last);
		result_t r;
		r = '0;
		r.kind        = kind;
		r.write_value = value;
		r.last_of_run = last;
		return r;
	endfunction

	// Finished result
	function automatic result_t make_fin(input logic found, input logic last_dev,
			input logic [63:0] rom, input logic [6:0] fam);
		result_t r;
		r = '0;
		r.kind               = KIND_FINISHED;
		r.found              = found;
		r.last_device        = last_dev;
		r.rom_code           = rom;
		r.family_discrepancy = fam;
		r.last_of_run        = 1'b1;
		return r;
	endfunction

endpackage

[rtl/owrs_core.sv]
// owrs_core: search state registers and the single-pass update for one bus event.
// Depends on owrs_pkg (codes, result_t, crc_byte, result builders).
module owrs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          mode,
	input  logic                restart,
	input  logic                presence,
	input  logic                true_bit,
	input  logic                complement_bit,
	output logic                push0,
	output logic                push1,
	output owrs_pkg::result_t   res0,
	output owrs_pkg::result_t   res1
);

	logic [63:0] rom_q, rom_d;
	logic [6:0]  prior_q, prior_d;
	logic [6:0]  fam_q, fam_d;
	logic        final_q, final_d;
	logic [7:0]  crc_q, crc_d;
	logic [6:0]  bp_q, bp_d;
	logic [6:0]  nz_q, nz_d;
	logic [1:0]  phase_q, phase_d;
	logic        push0_c, push1_c;

	// Bit-pair datapath
	logic [6:0]  bp_m1;
	logic [5:0]  idx;
	logic        dir;
	logic        zero_hit;
	logic [63:0] rom_bit;
	logic [7:0]  crc_bit;
	logic [6:0]  nz_bit;
	logic [6:0]  fam_bit;
	logic [7:0]  byte_sel;

	assign bp_m1    = bp_q - 7'd1;
	assign idx      = bp_m1[5:0];
	assign zero_hit = (true_bit == complement_bit) && !dir;
	assign nz_bit   = zero_hit ? bp_q : nz_q;
	assign fam_bit  = (zero_hit && (bp_q < owrs_pkg::FAMILY_LIMIT)) ? bp_q : fam_q;
	assign rom_bit  = (rom_q & ~(64'd1 << idx)) | ({63'd0, dir} << idx);
	assign byte_sel = rom_bit[{idx[5:3], 3'b000} +: 8];
	assign crc_bit  = (idx[2:0] == 3'd7) ? owrs_pkg::crc_byte(crc_q, byte_sel) : crc_q;

	// Direction: forced bit, remembered choice, one at the last discrepancy, else zero
	always_comb begin
		if (true_bit != complement_bit) begin
			dir = true_bit;
		end else if (bp_q < prior_q) begin
			dir = rom_q[idx];
		end else begin
			dir = (bp_q == prior_q);
		end
	end

	// Next state and results
	always_comb begin
		rom_d   = rom_q;
		prior_d = prior_q;
		fam_d   = fam_q;
		final_d = final_q;
		crc_d   = crc_q;
		bp_d    = bp_q;
		nz_d    = nz_q;
		phase_d = phase_q;
		push0_c = 1'b0;
		push1_c = 1'b0;
		res0    = '0;
		res1    = '0;
		case (mode)
			owrs_pkg::MODE_BEGIN: begin
				if (phase_q == owrs_pkg::PH_IDLE) begin
					push0_c = 1'b1;
					bp_d    = 7'd1;
					nz_d    = '0;
					crc_d   = '0;
					if (restart) begin
						prior_d = '0;
						fam_d   = '0;
						final_d = 1'b0;
					end
					if (final_q && !restart) begin
						// search already complete
						prior_d = '0;
						fam_d   = '0;
						final_d = 1'b0;
						res0    = owrs_pkg::make_fin(1'b0, 1'b0, rom_q, 7'd0);
					end else begin
						phase_d = owrs_pkg::PH_PRESENCE;
						res0    = owrs_pkg::make_cmd(owrs_pkg::KIND_RESET, 8'd0, 1'b1);
					end
				end
			end
			owrs_pkg::MODE_PRESENCE: begin
				if (phase_q == owrs_pkg::PH_PRESENCE) begin
					push0_c = 1'b1;
					if (!presence) begin
						prior_d = '0;
						fam_d   = '0;
						final_d = 1'b0;
						phase_d = owrs_pkg::PH_IDLE;
						res0    = owrs_pkg::make_fin(1'b0, 1'b0, rom_q, 7'd0);
					end else begin
						phase_d = owrs_pkg::PH_SEARCH;
						res0    = owrs_pkg::make_cmd(owrs_pkg::KIND_BYTE,
							owrs_pkg::SEARCH_CMD, 1'b1);
					end
				end
			end
			owrs_pkg::MODE_BITS: begin
				if (phase_q == owrs_pkg::PH_SEARCH) begin
					push0_c = 1'b1;
					if (true_bit && complement_bit) begin
						// nobody answered
						prior_d = '0;
						fam_d   = '0;
						final_d = 1'b0;
						phase_d = owrs_pkg::PH_IDLE;
						res0    = owrs_pkg::make_fin(1'b0, 1'b0, rom_q, 7'd0);
					end else begin
						rom_d = rom_bit;
						crc_d = crc_bit;
						nz_d  = nz_bit;
						fam_d = fam_bit;
						bp_d  = bp_q + 7'd1;
						if (idx != owrs_pkg::LAST_IDX) begin
							res0 = owrs_pkg::make_cmd(owrs_pkg::KIND_BIT, {7'd0, dir}, 1'b1);
						end else begin
							// all 64 bits in: check CRC and family byte
							res0    = owrs_pkg::make_cmd(owrs_pkg::KIND_BIT, {7'd0, dir},
								1'b0);
							push1_c = 1'b1;
							phase_d = owrs_pkg::PH_IDLE;
							if ((crc_bit == 8'd0) && (rom_bit[7:0] != 8'd0)) begin
								prior_d = nz_bit;
								final_d = (nz_bit == 7'd0) ? 1'b1 : final_q;
								res1    = owrs_pkg::make_fin(1'b1,
									(nz_bit == 7'd0) ? 1'b1 : final_q, rom_bit, fam_bit);
							end else begin
								prior_d = '0;
								fam_d   = '0;
								final_d = 1'b0;
								res1    = owrs_pkg::make_fin(1'b0, 1'b0, rom_bit, 7'd0);
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign push0 = accept && push0_c;
	assign push1 = accept && push1_c;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q   <= '0;
			prior_q <= '0;
			fam_q   <= '0;
			final_q <= 1'b0;
			crc_q   <= '0;
			bp_q    <= 7'd1;
			nz_q    <= '0;
			phase_q <= owrs_pkg::PH_IDLE;
		end else if (accept) begin
			rom_q   <= rom_d;
			prior_q <= prior_d;
			fam_q   <= fam_d;
			final_q <= final_d;
			crc_q   <= crc_d;
			bp_q    <= bp_d;
			nz_q    <= nz_d;
			phase_q <= phase_d;
		end
	end

endmodule

[rtl/owrs_result_queue.sv]
// owrs_result_queue: small result queue taking up to two results per cycle, one out.
// Depends on owrs_pkg (result_t).
module owrs_result_queue #(
	parameter int Depth = owrs_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  logic              push1,
	input  owrs_pkg::result_t res0,
	input  owrs_pkg::result_t res1,
	output logic              room2,
	output logic              out_valid,
	input  logic              out_ready,
	output owrs_pkg::result_t out_res
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	owrs_pkg::result_t    mem_q [Depth];
	logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]      cnt_q;
	logic [PtrW-1:0]      wr_ptr1;
	logic                 pop;
	logic [CntW-1:0]      n_push;

	assign wr_ptr1   = wr_ptr_q + PtrW'(1);
	assign pop       = out_valid && out_ready;
	assign n_push    = CntW'(push0) + CntW'(push1);
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign room2     = (cnt_q <= CntW'(Depth - 2));

	// Storage
	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push1) begin
			mem_q[wr_ptr1] <= res1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			cnt_q <= cnt_q + n_push - CntW'(pop);
		end
	end

endmodule

[rtl/one_wire_rom_search.sv]
// one_wire_rom_search: top level of the one-wire ROM search engine.
// Depends on owrs_pkg, owrs_core and owrs_result_queue.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid/in_ready, mode, restart,        | in
//           | presence, true_bit, complement_bit       |
//   result  | out_valid/out_ready, kind, write_value,  | out
//           | found, last_device, rom_code,            |
//           | family_discrepancy, last_of_run          |
//
// One input transaction per cycle while in_ready is high; each is handled in the cycle it is
// taken and its one or two results are registered into a QueueDepth-entry result queue,
// which presents them in order. in_ready is high while the queue has room for two results,
// so the queue depth sets how far a stalled result side can run ahead. Reset (arst_n) clears
// the search memory and empties the queue; no clearing pass is needed.
module one_wire_rom_search #(
	parameter int QueueDepth = owrs_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic        restart,
	input  logic        presence,
	input  logic        true_bit,
	input  logic        complement_bit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  write_value,
	output logic        found,
	output logic        last_device,
	output logic [63:0] rom_code,
	output logic [6:0]  family_discrepancy,
	output logic        last_of_run
);

	logic              accept;
	logic              push0, push1;
	logic              room2;
	owrs_pkg::result_t res0, res1, out_res;

	assign in_ready = room2;
	assign accept   = in_valid && in_ready;

	owrs_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.mode           (mode),
		.restart        (restart),
		.presence       (presence),
		.true_bit       (true_bit),
		.complement_bit (complement_bit),
		.push0          (push0),
		.push1          (push1),
		.res0           (res0),
		.res1           (res1)
	);

	owrs_result_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.res0      (res0),
		.res1      (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// Result fields
	assign kind               = out_res.kind;
	assign write_value        = out_res.write_value;
	assign found              = out_res.found;
	assign last_device        = out_res.last_device;
	assign rom_code           = out_res.rom_code;
	assign family_discrepancy = out_res.family_discrepancy;
	assign last_of_run        = out_res.last_of_run;

endmodule

[tb/one_wire_rom_search_tb.sv]
`timescale 1ns / 100ps
// one_wire_rom_search_tb: self-checking testbench for the one-wire ROM search engine.
// Depends on owrs_pkg and one_wire_rom_search; a bus of simulated devices answers the search.
module one_wire_rom_search_tb;

	localparam int ITEM_TARGET    = 1900;
	localparam int MAX_DEVICES    = 8;
	localparam int LONG_HOLD      = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;

	// Mode value with no meaning to the engine
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = owrs_pkg::MODE_BEGIN;
	logic        restart = 1'b0;
	logic        presence = 1'b0;
	logic        true_bit = 1'b0;
	logic        complement_bit = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  write_value;
	logic        found;
	logic        last_device;
	logic [63:0] rom_code;
	logic [6:0]  family_discrepancy;
	logic        last_of_run;

	one_wire_rom_search dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Search engine state as the testbench predicts it
	logic [63:0] srch_rom = '0;
	logic [6:0]  srch_disc = '0;
	logic [6:0]  srch_family = '0;
	logic        srch_last = 1'b0;
	logic [6:0]  srch_pos = 7'd1;
	logic [6:0]  srch_zero = '0;
	logic [1:0]  srch_phase = owrs_pkg::PH_IDLE;

	owrs_pkg::result_t engine_results_due[$];
	owrs_pkg::result_t oldest_due;
	int          useful_items = 0;
	int          errors = 0;

	// Simulated devices on the bus
	logic [63:0] bus_roms[$];
	bit          bus_live[MAX_DEVICES];

	// Gap and stall control
	bit          no_gaps = 1'b0;
	int          holds_asked = 0;
	int          holds_served = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	int          idle_cycles = 0;

	// Dallas CRC-8 over the first nbits of a code, bit 0 first
	function automatic logic [7:0] dallas_crc(input logic [63:0] code, input int nbits);
		logic [7:0] acc;
		logic       fb;
		acc = '0;
		for (int i = 0; i < nbits; i++) begin
			fb  = acc[0] ^ code[i];
			acc = acc >> 1;
			if (fb)
				acc = acc ^ owrs_pkg::CRC_POLY;
		end
		return acc;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int gap_length();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] with_crc(input logic [63:0] code);
		logic [63:0] c;
		c = code;
		c[63:56] = dallas_crc(c, 56);
		return c;
	endfunction

	task automatic forget_search();
		srch_disc   = '0;
		srch_family = '0;
		srch_last   = 1'b0;
	endtask

	task automatic queue_command(input logic [1:0] k, input logic [7:0] v, input logic fin);
		owrs_pkg::result_t r;
		r = '0;
		r.kind        = k;
		r.write_value = v;
		r.last_of_run = fin;
		engine_results_due.push_back(r);
	endtask

	task automatic queue_finished(input logic ok);
		owrs_pkg::result_t r;
		r = '0;
		r.kind               = owrs_pkg::KIND_FINISHED;
		r.found              = ok;
		r.last_device        = srch_last;
		r.rom_code           = srch_rom;
		r.family_discrepancy = srch_family;
		r.last_of_run        = 1'b1;
		engine_results_due.push_back(r);
	endtask

	// One accepted transaction: update the predicted state, queue the results it causes
	task automatic search_step(input logic [1:0] m, input logic r, input logic p,
			input logic t, input logic c, output logic dir);
		logic [5:0] idx;
		logic       ok;
		dir = 1'b0;
		case (m)
			owrs_pkg::MODE_BEGIN: if (srch_phase == owrs_pkg::PH_IDLE) begin
				useful_items++;
				if (r)
					forget_search();
				srch_pos  = 7'd1;
				srch_zero = '0;
				if (srch_last) begin
					// previous pass already found the last device
					forget_search();
					queue_finished(1'b0);
				end else begin
					srch_phase = owrs_pkg::PH_PRESENCE;
					queue_command(owrs_pkg::KIND_RESET, 8'd0, 1'b1);
				end
			end
			owrs_pkg::MODE_PRESENCE: if (srch_phase == owrs_pkg::PH_PRESENCE) begin
				useful_items++;
				if (!p) begin
					forget_search();
					srch_phase = owrs_pkg::PH_IDLE;
					queue_finished(1'b0);
				end else begin
					srch_phase = owrs_pkg::PH_SEARCH;
					queue_command(owrs_pkg::KIND_BYTE, owrs_pkg::SEARCH_CMD, 1'b1);
				end
			end
			owrs_pkg::MODE_BITS: if (srch_phase == owrs_pkg::PH_SEARCH) begin
				useful_items++;
				if (t && c) begin
					// nobody answered the slot pair
					forget_search();
					srch_phase = owrs_pkg::PH_IDLE;
					queue_finished(1'b0);
				end else begin
					idx = 6'(srch_pos - 7'd1);
					if (t != c) begin
						dir = t;
					end else begin
						// discrepancy: replay old path, take 1 at the last one, else 0
						if (srch_pos < srch_disc)
							dir = srch_rom[idx];
						else
							dir = (srch_pos == srch_disc);
						if (!dir) begin
							srch_zero = srch_pos;
							if (srch_zero < owrs_pkg::FAMILY_LIMIT)
								srch_family = srch_zero;
						end
					end
					srch_rom[idx] = dir;
					srch_pos      = srch_pos + 7'd1;
					if (idx != owrs_pkg::LAST_IDX) begin
						queue_command(owrs_pkg::KIND_BIT, {7'd0, dir}, 1'b1);
					end else begin
						queue_command(owrs_pkg::KIND_BIT, {7'd0, dir}, 1'b0);
						srch_phase = owrs_pkg::PH_IDLE;
						ok = 1'b0;
						if (dallas_crc(srch_rom, 64) == 8'd0) begin
							srch_disc = srch_zero;
							if (srch_disc == 7'd0)
								srch_last = 1'b1;
							ok = 1'b1;
						end
						if (!ok || srch_rom[7:0] == 8'd0) begin
							forget_search();
							ok = 1'b0;
						end
						queue_finished(ok);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Offer one transaction and wait until it is taken
	task automatic send_item(input logic [1:0] m, input logic r, input logic p,
			input logic t, input logic c, output logic dir);
		int gap;
		gap = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : gap_length();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		mode           <= m;
		restart        <= r;
		presence       <= p;
		true_bit       <= t;
		complement_bit <= c;
		do
			@(posedge clk);
		while (!in_ready);
		search_step(m, r, p, t, c, dir);
	endtask

	// A transaction the engine must ignore in its present phase
	task automatic send_stray();
		logic [1:0] wanted;
		logic       dir;
		wanted = (srch_phase == owrs_pkg::PH_IDLE) ? owrs_pkg::MODE_BEGIN :
			(srch_phase == owrs_pkg::PH_PRESENCE) ? owrs_pkg::MODE_PRESENCE :
			owrs_pkg::MODE_BITS;
		send_item(2'(wanted + 2'($urandom_range(1, 3))), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), dir);
	endtask

	task automatic build_bus(input int count);
		logic [63:0] code;
		bus_roms.delete();
		for (int i = 0; i < count; i++) begin
			if (i > 0 && $urandom_range(0, 99) < 60) begin
				// near relative of an earlier device: one bit apart below the CRC byte
				code = bus_roms[$urandom_range(0, i - 1)];
				code[$urandom_range(0, 55)] ^= 1'b1;
			end else begin
				code = {$urandom, $urandom};
				case ($urandom_range(0, 3))
					0: code[7:0] = 8'h28;
					1: code[7:0] = 8'h10;
					2: code[7:0] = 8'h22;
					default: ;
				endcase
			end
			bus_roms.push_back(with_crc(code));
		end
	endtask

	// One search pass against the simulated bus; noise is a percentage of upsets
	task automatic run_search_pass(input logic fresh, input int noise);
		logic       dir;
		logic       tbit;
		logic       cbit;
		logic       answer;
		logic [5:0] idx;
		send_item(owrs_pkg::MODE_BEGIN, fresh, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dir);
		if (srch_phase != owrs_pkg::PH_PRESENCE)
			return;
		if ($urandom_range(0, 99) < noise)
			send_stray();
		answer = (bus_roms.size() != 0);
		if ($urandom_range(0, 99) < noise)
			answer = !answer;
		send_item(owrs_pkg::MODE_PRESENCE, 1'($urandom_range(0, 1)), answer,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dir);
		if (srch_phase != owrs_pkg::PH_SEARCH)
			return;
		foreach (bus_live[i])
			bus_live[i] = 1'b1;
		for (int b = 0; b < 64; b++) begin
			idx  = 6'(b);
			tbit = 1'b1;
			cbit = 1'b1;
			// open-drain bus: a zero from any live device wins
			foreach (bus_roms[i]) begin
				if (bus_live[i]) begin
					if (bus_roms[i][idx])
						cbit = 1'b0;
					else
						tbit = 1'b0;
				end
			end
			if ($urandom_range(0, 99) < noise) begin
				if ($urandom_range(0, 1))
					tbit = !tbit;
				else
					cbit = !cbit;
			end
			if ($urandom_range(0, 99) < noise)
				send_stray();
			send_item(owrs_pkg::MODE_BITS, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), tbit, cbit, dir);
			if (srch_phase != owrs_pkg::PH_SEARCH)
				return;
			foreach (bus_roms[i])
				if (bus_roms[i][idx] != dir)
					bus_live[i] = 1'b0;
		end
	endtask

	// Walk through every device, then on past the end; later passes are skipped once the item budget is spent
	task automatic enumerate_bus(input int noise);
		run_search_pass(1'b1, noise);
		repeat (bus_roms.size() + 2)
			if (useful_items < ITEM_TARGET)
				run_search_pass($urandom_range(0, 99) < 5, noise);
	endtask

	// Out-of-phase items, no presence, an empty slot pair, a forced then a mixed discrepancy
	task automatic test_phase_handling();
		logic dir;
		send_item(owrs_pkg::MODE_PRESENCE, 1'b0, 1'b1, 1'b0, 1'b0, dir);
		send_item(owrs_pkg::MODE_BITS, 1'b0, 1'b0, 1'b0, 1'b1, dir);
		send_item(MODE_SPARE, 1'b1, 1'b1, 1'b1, 1'b1, dir);
		send_item(owrs_pkg::MODE_BEGIN, 1'b1, 1'b0, 1'b0, 1'b0, dir);
		send_item(owrs_pkg::MODE_BEGIN, 1'b0, 1'b1, 1'b1, 1'b1, dir);
		send_item(owrs_pkg::MODE_BITS, 1'b1, 1'b1, 1'b1, 1'b1, dir);
		send_item(owrs_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b1, 1'b1, dir);
		send_item(owrs_pkg::MODE_BEGIN, 1'b0, 1'b0, 1'b0, 1'b0, dir);
		send_item(owrs_pkg::MODE_PRESENCE, 1'b0, 1'b1, 1'b0, 1'b0, dir);
		send_item(owrs_pkg::MODE_PRESENCE, 1'b0, 1'b0, 1'b0, 1'b0, dir);
		send_item(owrs_pkg::MODE_BEGIN, 1'b1, 1'b0, 1'b0, 1'b0, dir);
		send_item(owrs_pkg::MODE_BITS, 1'b0, 1'b0, 1'b1, 1'b1, dir);
		send_item(owrs_pkg::MODE_BEGIN, 1'b1, 1'b1, 1'b0, 1'b1, dir);
		send_item(owrs_pkg::MODE_PRESENCE, 1'b1, 1'b1, 1'b1, 1'b0, dir);
		send_item(owrs_pkg::MODE_BITS, 1'b0, 1'b0, 1'b1, 1'b0, dir);
		send_item(owrs_pkg::MODE_BITS, 1'b1, 1'b1, 1'b0, 1'b1, dir);
		send_item(owrs_pkg::MODE_BITS, 1'b0, 1'b1, 1'b0, 1'b0, dir);
		send_item(MODE_SPARE, 1'b0, 1'b0, 1'b0, 1'b0, dir);
		send_item(owrs_pkg::MODE_BITS, 1'b1, 1'b0, 1'b1, 1'b1, dir);
	endtask

	// Bad CRC, zero family byte, and the all-ones / near-zero codes
	task automatic test_odd_codes();
		logic [63:0] code;
		build_bus(1);
		bus_roms[0][63:56] = ~bus_roms[0][63:56];
		run_search_pass(1'b1, 0);
		code = {$urandom, $urandom};
		code[7:0] = 8'h00;
		bus_roms.delete();
		bus_roms.push_back(with_crc(code));
		run_search_pass(1'b1, 0);
		bus_roms.delete();
		bus_roms.push_back(with_crc({8'h00, 48'hFFFF_FFFF_FFFF, 8'hFF}));
		bus_roms.push_back(with_crc({8'h00, 48'h0, 8'h01}));
		enumerate_bus(0);
	endtask

	// Result side stalls for a long stretch while the sender keeps offering
	task automatic test_result_backpressure();
		no_gaps     <= 1'b1;
		holds_asked <= holds_asked + 1;
		build_bus(3);
		enumerate_bus(0);
		no_gaps <= 1'b0;
	endtask

	// Random buses until enough transactions have gone through
	task automatic test_random_buses();
		while (useful_items < ITEM_TARGET) begin
			build_bus(($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 6));
			no_gaps <= ($urandom_range(0, 99) < 15);
			enumerate_bus(($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 4));
		end
		no_gaps <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_phase_handling();
		test_odd_codes();
		test_result_backpressure();
		test_random_buses();
		in_valid <= 1'b0;
		while (engine_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Result side: random stalls plus the requested long hold
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left    <= LONG_HOLD;
			out_ready    <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
			stall_left <= gap_length() - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (engine_results_due.size() == 0) begin
				$display("%0t: unexpected result, actual kind %0d", $time, kind);
				errors++;
			end else begin
				oldest_due = engine_results_due.pop_front();
				check_field("kind", 64'(oldest_due.kind), 64'(kind));
				check_field("write_value", 64'(oldest_due.write_value), 64'(write_value));
				check_field("found", 64'(oldest_due.found), 64'(found));
				check_field("last_device", 64'(oldest_due.last_device), 64'(last_device));
				check_field("rom_code", oldest_due.rom_code, rom_code);
				check_field("family_discrepancy", 64'(oldest_due.family_discrepancy),
					64'(family_discrepancy));
				check_field("last_of_run", 64'(oldest_due.last_of_run), 64'(last_of_run));
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				engine_results_due.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

[filelist.f]
rtl/owrs_pkg.sv
rtl/owrs_core.sv
rtl/owrs_result_queue.sv
rtl/one_wire_rom_search.sv
tb/one_wire_rom_search_tb.sv
